@@ design/pav_pkg.sv @@
// shared types and constants for the pixel accumulate and average unit
package pav_pkg;

  localparam int CFG_W    = 9;
  localparam int COL_W    = 8;
  localparam int SAMPLE_W = 24;
  localparam int PASS_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int DISP_W   = 16;
  localparam int FRAC_W   = 16;

  typedef enum logic [1:0] {
    MODE_ACCUM = 2'd0,
    MODE_SET   = 2'd1,
    MODE_PASS  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

endpackage

@@ design/pav_ram.sv @@
// generic simple dual-port ram with registered read
module pav_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/pav_div.sv @@
// one channel: average of a sum over the pass count, clamped and scaled to 8 bits
module pav_div #(
  parameter int SUM_BITS = 40
) (
  input  logic                               clk,
  input  logic                               load,
  input  logic                               run,
  input  logic signed [SUM_BITS-1:0]         sum,
  input  logic [pav_pkg::PASS_W-1:0]         pass_count,
  output logic [pav_pkg::BYTE_W-1:0]         quot
);
  import pav_pkg::*;

  localparam int CW = SUM_BITS + 34;
  localparam int NW = 42;

  logic [CW-1:0] one_ext;
  logic [CW-1:0] sum_ext;
  logic [31:0]   s32;
  logic [NW-1:0] num;
  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic          fixed;

  assign one_ext = CW'({pass_count, {FRAC_W{1'b0}}});
  assign sum_ext = CW'($unsigned(sum));
  assign s32     = sum_ext[31:0];
  // 510*s + one, the half-up rounding numerator
  assign num = (NW'(s32) << 9) - (NW'(s32) << 1) + NW'({pass_count, {FRAC_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= num;
      dsh   <= NW'({pass_count, {(FRAC_W + 1){1'b0}}}) << (BYTE_W - 1);
      fixed <= 1'b1;
      if (pass_count == '0) begin
        quot <= sum[SUM_BITS-1] ? '0 : '1;
      end else if (sum[SUM_BITS-1] || sum == '0) begin
        quot <= '0;
      end else if (sum_ext >= one_ext) begin
        quot <= '1;
      end else begin
        quot  <= '0;
        fixed <= 1'b0;
      end
    end else if (run && !fixed) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[BYTE_W-2:0], 1'b1};
      end else begin
        quot <= {quot[BYTE_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

@@ design/pixel_accumulate_average_to_rgb8_unit.sv @@
// top level: accumulation buffer with averaged 8-bit rgb readout
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+---------------------
//  item in  | mode pos_col pos_row red_in green_in blue_in   | start & !busy
//  result   | display_index red/green/blue_out position_error| result_valid, 1 cycle
//  config   | cfg_index cfg_data                             | cfg_write
//
// a pixel word passes through address, ram read, modify/write back, load,
// 8 restoring-division steps (one quotient bit per cycle) and output.
// begin pass and an out-of-range position are handled in idle without raising busy.
// clear and reset sweep the sum ram one entry a cycle, all MAX_WIDTH*MAX_HEIGHT
// entries (65536 at default size), with busy high.
// results cannot be stalled; config writes are taken in any cycle.
module pixel_accumulate_average_to_rgb8_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int SUM_BITS   = 40
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           mode,
  input  logic [pav_pkg::COL_W-1:0]            pos_col,
  input  logic [pav_pkg::COL_W-1:0]            pos_row,
  input  logic signed [pav_pkg::SAMPLE_W-1:0]  red_in,
  input  logic signed [pav_pkg::SAMPLE_W-1:0]  green_in,
  input  logic signed [pav_pkg::SAMPLE_W-1:0]  blue_in,
  output logic                                 result_valid,
  output logic [pav_pkg::DISP_W-1:0]           display_index,
  output logic [pav_pkg::BYTE_W-1:0]           red_out,
  output logic [pav_pkg::BYTE_W-1:0]           green_out,
  output logic [pav_pkg::BYTE_W-1:0]           blue_out,
  output logic                                 position_error,
  input  logic                                 cfg_write,
  input  logic                                 cfg_index,
  input  logic [pav_pkg::CFG_W-1:0]            cfg_data
);
  import pav_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = SUM_BITS;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int STEPS = BYTE_W;
  localparam int SCW   = $clog2(STEPS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_READ   = 7'b0000100,
    S_MODIFY = 7'b0001000,
    S_LOAD   = 7'b0010000,
    S_DIVIDE = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0]    image_width;
  logic [CFG_W-1:0]    image_height;
  logic [PASS_W-1:0]   pass_count;
  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       addr;
  logic [DISP_W-1:0]   disp;
  logic [SCW-1:0]      step;
  logic                accum;
  logic signed [SAMPLE_W-1:0] smp_r, smp_g, smp_b;
  logic signed [SW-1:0] sum_r, sum_g, sum_b;

  logic [WW-1:0]       weff;
  logic [HW-1:0]       heff;
  logic                out_of_range;
  logic [31:0]         addr_full;
  logic [31:0]         disp_full;
  logic                accept;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [3*SW-1:0]     ram_wdata;
  logic [3*SW-1:0]     ram_rdata;
  logic signed [SW-1:0] new_r, new_g, new_b;
  logic [BYTE_W-1:0]   q_r, q_g, q_b;

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                    input logic signed [SAMPLE_W-1:0] b,
                                                    input logic do_add);
    logic signed [SW:0] t;
    t = {a[SW-1], a} + {{(SW + 1 - SAMPLE_W){b[SAMPLE_W-1]}}, b};
    if (!do_add) begin
      sat_add = {{(SW - SAMPLE_W){b[SAMPLE_W-1]}}, b};
    end else if (t[SW] != t[SW-1]) begin
      sat_add = t[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
    end else begin
      sat_add = t[SW-1:0];
    end
  endfunction

  // effective size, clamped to the buffer, a zero register acting as one
  always_comb begin
    if (image_width == '0) begin
      weff = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(image_width);
    end
    if (image_height == '0) begin
      heff = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      heff = HW'(MAX_HEIGHT);
    end else begin
      heff = HW'(image_height);
    end
  end

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign out_of_range = (32'(pos_col) >= 32'(weff)) || (32'(pos_row) >= 32'(heff));
  assign addr_full    = 32'(pos_row) * 32'(weff) + 32'(pos_col);
  assign disp_full    = (32'(heff) - 32'd1 - 32'(pos_row)) * 32'(weff) + 32'(pos_col);

  assign new_r = sat_add($signed(ram_rdata[3*SW-1:2*SW]), smp_r, accum);
  assign new_g = sat_add($signed(ram_rdata[2*SW-1:SW]),   smp_g, accum);
  assign new_b = sat_add($signed(ram_rdata[SW-1:0]),      smp_b, accum);

  assign ram_we    = (state == S_CLEAR) || (state == S_MODIFY);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : addr;
  assign ram_wdata = (state == S_CLEAR) ? '0 : {new_r, new_g, new_b};

  pav_ram #(.WIDTH(3 * SW), .DEPTH(DEPTH)) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_READ),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  pav_div #(.SUM_BITS(SW)) u_div_r (
    .clk(clk), .load(state == S_LOAD), .run(state == S_DIVIDE),
    .sum(sum_r), .pass_count(pass_count), .quot(q_r)
  );
  pav_div #(.SUM_BITS(SW)) u_div_g (
    .clk(clk), .load(state == S_LOAD), .run(state == S_DIVIDE),
    .sum(sum_g), .pass_count(pass_count), .quot(q_g)
  );
  pav_div #(.SUM_BITS(SW)) u_div_b (
    .clk(clk), .load(state == S_LOAD), .run(state == S_DIVIDE),
    .sum(sum_b), .pass_count(pass_count), .quot(q_b)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_CLEAR) begin
            state_next = S_CLEAR;
          end else if ((mode == MODE_ACCUM || mode == MODE_SET) && !out_of_range) begin
            state_next = S_READ;
          end
        end
      end
      S_CLEAR:  state_next = (clr_addr == AW'(DEPTH - 1)) ? S_IDLE : S_CLEAR;
      S_READ:   state_next = S_MODIFY;
      S_MODIFY: state_next = S_LOAD;
      S_LOAD:   state_next = S_DIVIDE;
      S_DIVIDE: state_next = (step == SCW'(STEPS - 1)) ? S_FINISH : S_DIVIDE;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      pass_count   <= '0;
      image_width  <= CFG_W'(256);
      image_height <= CFG_W'(256);
      result_valid <= 1'b0;
      step         <= '0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == REG_WIDTH) begin
          image_width <= cfg_data;
        end else begin
          image_height <= cfg_data;
        end
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_DIVIDE) begin
        step <= step + SCW'(1);
      end else begin
        step <= '0;
      end
      if (accept) begin
        case (mode)
          MODE_PASS: begin
            if (pass_count != '1) begin
              pass_count <= pass_count + PASS_W'(1);
            end
          end
          MODE_CLEAR: begin
            pass_count <= '0;
            clr_addr   <= '0;
          end
          default: begin
            result_valid <= out_of_range;
          end
        endcase
      end
      if (state == S_FINISH) begin
        result_valid <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      addr           <= addr_full[AW-1:0];
      disp           <= disp_full[DISP_W-1:0];
      accum          <= (mode == MODE_ACCUM);
      smp_r          <= red_in;
      smp_g          <= green_in;
      smp_b          <= blue_in;
      display_index  <= '0;
      red_out        <= '0;
      green_out      <= '0;
      blue_out       <= '0;
      position_error <= 1'b1;
    end
    if (state == S_MODIFY) begin
      sum_r <= new_r;
      sum_g <= new_g;
      sum_b <= new_b;
    end
    if (state == S_FINISH) begin
      display_index  <= disp;
      red_out        <= q_r;
      green_out      <= q_g;
      blue_out       <= q_b;
      position_error <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result strobe while busy");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_MODIFY))
    else $error("sum ram written outside clear or modify");

  a_pixel_read: assert property (@(posedge clk) disable iff (rst)
    accept && (mode == MODE_ACCUM || mode == MODE_SET) && !out_of_range
    |=> state == S_READ)
    else $error("in-range pixel word did not start a read");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && position_error |-> display_index == '0 && red_out == '0)
    else $error("position error result carries data");
`endif

endmodule

@@ verif/pixel_accumulate_average_to_rgb8_unit_tb.sv @@
// testbench for the pixel accumulate and average unit: directed and random words, scoreboard check
module pixel_accumulate_average_to_rgb8_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pav_pkg::*;

  typedef struct {
    logic [DISP_W-1:0] disp;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              err;
  } pixel_word_t;

  class pixel_scoreboard;
    longint      red_acc[0:65535];
    longint      green_acc[0:65535];
    longint      blue_acc[0:65535];
    int unsigned passes;
    int unsigned img_w;
    int unsigned img_h;
    pixel_word_t pending_q[$];
    int          errors;

    function new();
      foreach (red_acc[i]) begin
        red_acc[i] = 0;
        green_acc[i] = 0;
        blue_acc[i] = 0;
      end
      passes = 0;
      img_w = 256;
      img_h = 256;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(logic idx, logic [CFG_W-1:0] data);
      if (idx == REG_WIDTH) img_w = data;
      else img_h = data;
    endfunction

    function int unsigned clamp_size(int unsigned v);
      if (v < 1) return 1;
      if (v > 256) return 256;
      return v;
    endfunction

    function longint sat_add(longint a, longint b);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< 39) - 1;
      lo = -hi - 1;
      if (b > 0 && a > hi - b) return hi;
      if (b < 0 && a < lo - b) return lo;
      return a + b;
    endfunction

    // average over passes, clamped to [0,1], scaled to 255 rounding half up
    function logic [7:0] avg_byte(longint s);
      longint unsigned one;
      longint unsigned num;
      if (passes == 0) return (s >= 0) ? 8'd255 : 8'd0;
      if (s <= 0) return 8'd0;
      one = longint'(passes) << 16;
      if (longint'(s) >= longint'(one)) return 8'd255;
      num = 2 * longint'(s) * 255 + one;
      return 8'(num / (2 * one));
    endfunction

    function void note_word(mode_t m, logic [7:0] col, logic [7:0] row,
                            logic signed [23:0] r, logic signed [23:0] g,
                            logic signed [23:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned idx;
      pixel_word_t e;
      if (m == MODE_PASS) begin
        if (passes < 65535) passes++;
        return;
      end
      if (m == MODE_CLEAR) begin
        foreach (red_acc[i]) begin
          red_acc[i] = 0;
          green_acc[i] = 0;
          blue_acc[i] = 0;
        end
        passes = 0;
        return;
      end
      w = clamp_size(img_w);
      h = clamp_size(img_h);
      if (col >= w || row >= h) begin
        e = '{disp: '0, red: '0, green: '0, blue: '0, err: 1'b1};
        pending_q.push_back(e);
        return;
      end
      idx = row * w + col;
      if (m == MODE_ACCUM) begin
        red_acc[idx] = sat_add(red_acc[idx], longint'(r));
        green_acc[idx] = sat_add(green_acc[idx], longint'(g));
        blue_acc[idx] = sat_add(blue_acc[idx], longint'(b));
      end else begin
        red_acc[idx] = longint'(r);
        green_acc[idx] = longint'(g);
        blue_acc[idx] = longint'(b);
      end
      e.disp = 16'((h - 1 - row) * w + col);
      e.red = avg_byte(red_acc[idx]);
      e.green = avg_byte(green_acc[idx]);
      e.blue = avg_byte(blue_acc[idx]);
      e.err = 1'b0;
      pending_q.push_back(e);
    endfunction

    task check_word(pixel_word_t got);
      pixel_word_t e;
      if (pending_q.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = pending_q.pop_front();
      if (got.disp !== e.disp)
        report($sformatf("display_index %0d, expected %0d", got.disp, e.disp));
      if (got.red !== e.red)
        report($sformatf("red_out %0d, expected %0d", got.red, e.red));
      if (got.green !== e.green)
        report($sformatf("green_out %0d, expected %0d", got.green, e.green));
      if (got.blue !== e.blue)
        report($sformatf("blue_out %0d, expected %0d", got.blue, e.blue));
      if (got.err !== e.err)
        report($sformatf("position_error %0b, expected %0b", got.err, e.err));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode = MODE_ACCUM;
  logic [COL_W-1:0] pos_col = '0;
  logic [COL_W-1:0] pos_row = '0;
  logic signed [SAMPLE_W-1:0] red_in = '0;
  logic signed [SAMPLE_W-1:0] green_in = '0;
  logic signed [SAMPLE_W-1:0] blue_in = '0;
  logic result_valid;
  logic [DISP_W-1:0] display_index;
  logic [BYTE_W-1:0] red_out;
  logic [BYTE_W-1:0] green_out;
  logic [BYTE_W-1:0] blue_out;
  logic position_error;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  pixel_scoreboard sb = new();
  bit no_idle = 1'b0;

  always #1 clk = ~clk;

  pixel_accumulate_average_to_rgb8_unit uut (.*);

  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_word('{disp: display_index, red: red_out, green: green_out,
                      blue: blue_out, err: position_error});
  end

  // called at a falling edge, returns at a falling edge
  task send_word(mode_t m, logic [7:0] col, logic [7:0] row,
                 logic signed [23:0] r, logic signed [23:0] g,
                 logic signed [23:0] b);
    start <= 1'b1;
    mode <= m;
    pos_col <= col;
    pos_row <= row;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (busy);
    sb.note_word(m, col, row, r, g, b);
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task write_reg(logic idx, logic [CFG_W-1:0] data);
    start <= 1'b0;
    while (sb.pending_q.size() != 0 || busy) @(negedge clk);
    // a begin pass or clear may still be in flight without a result
    repeat (16) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function logic signed [23:0] rand_sample();
    case ($urandom_range(9))
      6: return 24'($urandom);
      7: return 24'sd0;
      8: return 24'sd65536;
      9: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      default: return $signed(24'($urandom_range(98304))) - 24'sd16384;
    endcase
  endfunction

  task random_phase(int unsigned w, int unsigned h, int n, bit with_clear);
    int unsigned ew;
    int unsigned eh;
    int unsigned pick;
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
    ew = sb.clamp_size(w);
    eh = sb.clamp_size(h);
    if (with_clear) send_word(MODE_CLEAR, 0, 0, 0, 0, 0);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 10)
        send_word($urandom_range(1) ? MODE_ACCUM : MODE_SET, 8'($urandom), 8'($urandom),
                  rand_sample(), rand_sample(), rand_sample());
      else if (pick < 22)
        send_word(MODE_PASS, 8'($urandom), 8'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom));
      else
        send_word(pick < 85 ? MODE_ACCUM : MODE_SET, 8'($urandom_range(ew - 1)),
                  8'($urandom_range(eh - 1)), rand_sample(), rand_sample(), rand_sample());
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero pass count, sign decides
    send_word(MODE_SET, 0, 0, 24'sd0, -24'sd1, 24'sh7FFFFF);
    send_word(MODE_ACCUM, 255, 255, 24'sh800000, 24'sh800000, 24'sh800000);
    send_word(MODE_PASS, 0, 0, 0, 0, 0);
    send_word(MODE_SET, 1, 0, 24'sd65536, 24'sd32768, 24'sd32767);
    send_word(MODE_ACCUM, 1, 0, 24'sd65536, 24'sd1, -24'sd1);
    send_word(MODE_PASS, 0, 0, 0, 0, 0);
    send_word(MODE_PASS, 0, 0, 0, 0, 0);
    send_word(MODE_ACCUM, 1, 0, 24'sd98304, 24'sd65535, 24'sd0);
    send_word(MODE_SET, 7, 9, 24'sh7FFFFF, 24'sd131072, -24'sd65536);
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    send_word(MODE_ACCUM, 3, 0, 24'sd1, 24'sd1, 24'sd1);
    send_word(MODE_SET, 0, 2, 24'sd1, 24'sd1, 24'sd1);
    send_word(MODE_ACCUM, 255, 255, 24'sd1, 24'sd1, 24'sd1);
    send_word(MODE_SET, 2, 1, 24'sd40000, 24'sd20000, 24'sd60000);
    // zero size registers act as one
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    send_word(MODE_ACCUM, 0, 0, 24'sd50000, 24'sd100, -24'sd100);
    send_word(MODE_ACCUM, 1, 0, 24'sd1, 24'sd1, 24'sd1);
    send_word(MODE_ACCUM, 0, 1, 24'sd1, 24'sd1, 24'sd1);
    // oversize registers act as the maximum
    write_reg(REG_WIDTH, 511);
    write_reg(REG_HEIGHT, 511);
    send_word(MODE_ACCUM, 255, 255, 24'sd30000, 24'sd30000, 24'sd30000);
    send_word(MODE_CLEAR, 0, 0, 0, 0, 0);
    send_word(MODE_ACCUM, 255, 255, 24'sd1, -24'sd1, 24'sd0);

    random_phase(4, 3, 70, 1'b0);
    random_phase(1, 7, 60, 1'b0);
    no_idle = 1'b1;
    random_phase(16, 16, 70, 1'b0);
    no_idle = 1'b0;
    random_phase(256, 256, 70, 1'b0);
    random_phase(9, 1, 60, 1'b1);
    random_phase(511, 0, 60, 1'b0);
    random_phase(5, 5, 70, 1'b1);
    random_phase(2, 2, 60, 1'b0);

    // a few more passes, then small pixels
    for (int k = 0; k < 5; k++) send_word(MODE_PASS, 0, 0, 0, 0, 0);
    for (int k = 0; k < 20; k++)
      send_word(MODE_ACCUM, 8'($urandom_range(1)), 8'($urandom_range(1)), rand_sample(),
                rand_sample(), rand_sample());
    send_word(MODE_CLEAR, 0, 0, 0, 0, 0);
    send_word(MODE_ACCUM, 1, 1, -24'sd5, 24'sd5, 24'sd0);

    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
